// ===== rtl/core/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg: shared definitions of the permutation code encoder
// Sizes, the sequencer state type, control structs and the code-width
// helper functions used by the encoder's modules.
// ----------------------------------------------------------------------------
package pce_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int ELEM_W       = 4;
   localparam int SIZE_W       = 5;
   localparam int CODE_W       = 4;
   localparam int WIDTH_W      = 3;
   localparam int ACC_W        = 16;
   localparam int BITS_W       = 4;
   localparam int BYTE_W       = 8;

   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_ELEMENTS);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
   localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'b11111111;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctrl_type;

   typedef struct packed {
      logic clear;
      logic append;
      logic shift;
   } pack_ctrl_type;

   // Number of significant bits of a code index.
   function automatic logic [WIDTH_W-1:0] bit_len(input logic [CODE_W-1:0] v);
      logic [WIDTH_W-1:0] n;
      begin
         priority if (v[3]) n = WIDTH_W'(4);
         else if (v[2])     n = WIDTH_W'(3);
         else if (v[1])     n = WIDTH_W'(2);
         else if (v[0])     n = WIDTH_W'(1);
         else               n = WIDTH_W'(0);
         return n;
      end
   endfunction

   // Mask that keeps the low width bits of a code.
   function automatic logic [CODE_W-1:0] code_mask(input logic [WIDTH_W-1:0] width);
      logic [CODE_W:0] m;
      begin
         m = ((CODE_W+1)'(1) << width) - (CODE_W+1)'(1);
         return m[CODE_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/pce_scan_unit.sv =====
// ----------------------------------------------------------------------------
// pce_scan_unit: shared compare and count unit
// Compares one stored element per cycle against the current index and
// counts the elements below it.
// ----------------------------------------------------------------------------
module pce_scan_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  pce_pkg::scan_ctrl_type      ctrl,
   input  logic [pce_pkg::ELEM_W-1:0]  value,
   input  logic [pce_pkg::CODE_W-1:0]  target,
   output logic                        match,
   output logic [pce_pkg::CODE_W-1:0]  code_next
);

   logic [pce_pkg::CODE_W-1:0] code_ff;
   logic [pce_pkg::CODE_W-1:0] code_in;
   logic                       below;

   assign match     = (value == target);
   assign below     = (value < target);
   assign code_next = code_ff + pce_pkg::CODE_W'(below);

   always_comb begin
      code_in = code_ff;
      if (ctrl.clear) begin
         code_in = '0;
      end else if (ctrl.step) begin
         code_in = code_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
      end else begin
         code_ff <= code_in;
      end
   end

endmodule

// ===== rtl/core/pce_bit_packer.sv =====
// ----------------------------------------------------------------------------
// pce_bit_packer: bit accumulator of the encoder
// Appends variable-width codes least significant bit first and hands
// out the low byte.
// ----------------------------------------------------------------------------
module pce_bit_packer (
   input  logic                         clock,
   input  logic                         reset,
   input  pce_pkg::pack_ctrl_type       ctrl,
   input  logic [pce_pkg::CODE_W-1:0]   code,
   input  logic [pce_pkg::WIDTH_W-1:0]  width,
   output logic [pce_pkg::BYTE_W-1:0]   low_byte,
   output logic [pce_pkg::BITS_W-1:0]   bit_count
);

   logic [pce_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [pce_pkg::BITS_W-1:0] bits_ff, bits_in;
   logic [pce_pkg::CODE_W-1:0] masked;

   assign masked    = code & pce_pkg::code_mask(width);
   assign low_byte  = acc_ff[pce_pkg::BYTE_W-1:0] & pce_pkg::BYTE_MASK;
   assign bit_count = bits_ff;

   always_comb begin
      acc_in  = acc_ff;
      bits_in = bits_ff;
      priority if (ctrl.clear) begin
         acc_in  = '0;
         bits_in = '0;
      end else if (ctrl.append) begin
         acc_in  = acc_ff | (pce_pkg::ACC_W'(masked) << bits_ff);
         bits_in = bits_ff + pce_pkg::BITS_W'(width);
      end else if (ctrl.shift) begin
         acc_in  = acc_ff >> pce_pkg::BYTE_W;
         bits_in = (bits_ff >= pce_pkg::BITS_W'(pce_pkg::BYTE_W)) ?
                   bits_ff - pce_pkg::BITS_W'(pce_pkg::BYTE_W) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         bits_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         bits_ff <= bits_in;
      end
   end

endmodule

// ===== rtl/core/permutation_code_encoder.sv =====
// ----------------------------------------------------------------------------
// permutation_code_encoder: Lehmer-style permutation code encoder
// Loads a permutation one element per item and streams out its packed codes.
// ----------------------------------------------------------------------------
// The block takes perm_size elements (clamped to 2..16) on the req channel,
// one per item while req_tready is high. The item that completes the load
// starts the encoding, and req_tready stays low until the check state that
// follows the last byte is over. For each index i from size-1 down to 1 a
// single compare and count unit scans the stored elements, one per cycle, and
// stops at the first element equal to i or at the end of the set; the code is
// the count of earlier elements below i. The code, with width bitlen(i), goes
// into the bit accumulator at the end of the scan, and the check state
// follows. Each byte is held on the rsp channel until it is taken and is
// followed by another check state. An encoding at size 16 packs into seven
// bytes. The scan unit, visiting one element per cycle, sets the length of
// the encoding.
module permutation_code_encoder (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] element_value, [7:4] zero
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] packed_byte
   output logic        rsp_tlast,   // last_byte
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W  = pce_pkg::IDX_W;
   localparam int SIZE_W = pce_pkg::SIZE_W;
   localparam int BITS_W = pce_pkg::BITS_W;

   // Configuration register. Only one register exists, so every address
   // selects it.
   logic [SIZE_W-1:0] perm_size_ff;
   logic              csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {{(32-SIZE_W){1'b0}}, perm_size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_size_ff <= pce_pkg::SIZE_RESET;
      end else if (csr_write) begin
         perm_size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   // The effective size is the register clamped to the supported range.
   logic [SIZE_W-1:0] eff_size;
   logic [IDX_W-1:0]  last_idx;

   always_comb begin
      priority if (perm_size_ff < pce_pkg::SIZE_MIN) begin
         eff_size = pce_pkg::SIZE_MIN;
      end else if (perm_size_ff > pce_pkg::SIZE_MAX) begin
         eff_size = pce_pkg::SIZE_MAX;
      end else begin
         eff_size = perm_size_ff;
      end
   end

   assign last_idx = IDX_W'(eff_size - SIZE_W'(1));

   // Sequencer registers.
   pce_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   // Element store, written once per loaded item. Entries are only read
   // after they have been loaded, so no reset is needed.
   logic [pce_pkg::ELEM_W-1:0] element_store_ff [pce_pkg::MAX_ELEMENTS];
   logic                       store_write;

   logic                            req_accept;
   logic                            load_done;
   logic                            scan_match;
   logic [pce_pkg::CODE_W-1:0]      scan_code;
   logic                            scan_done;
   logic [7:0]                      pack_byte;
   logic [BITS_W-1:0]               pack_bits;
   logic                            emit_now;
   logic                            at_last_index;
   pce_pkg::scan_ctrl_type          scan_ctrl;
   pce_pkg::pack_ctrl_type          pack_ctrl;

   assign req_tready    = (state_ff == pce_pkg::ST_LOAD);
   assign req_accept    = req_tvalid && req_tready;
   assign store_write   = req_accept;
   assign load_done     = ({1'b0, count_ff} + SIZE_W'(1)) >= eff_size;
   assign scan_done     = scan_match || (j_ff == last_idx);
   assign at_last_index = (i_ff == IDX_W'(1));
   // A byte is ready when eight bits are held, or when the last code has
   // been packed and some bits remain.
   assign emit_now      = (pack_bits >= BITS_W'(8)) ||
                          (at_last_index && (pack_bits != '0));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   pce_scan_unit u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .value     (element_store_ff[j_ff]),
      .target    (pce_pkg::CODE_W'(i_ff)),
      .match     (scan_match),
      .code_next (scan_code)
   );

   pce_bit_packer u_pack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pack_ctrl),
      .code      (scan_code),
      .width     (pce_pkg::bit_len(pce_pkg::CODE_W'(i_ff))),
      .low_byte  (pack_byte),
      .bit_count (pack_bits)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      scan_ctrl    = '0;
      pack_ctrl    = '0;
      unique case (state_ff)
         pce_pkg::ST_LOAD: begin
            if (req_accept) begin
               if (load_done) begin
                  count_in        = '0;
                  i_in            = last_idx;
                  j_in            = '0;
                  scan_ctrl.clear = 1'b1;
                  pack_ctrl.clear = 1'b1;
                  state_in        = pce_pkg::ST_SCAN;
               end else begin
                  count_in = count_ff + IDX_W'(1);
               end
            end
         end
         pce_pkg::ST_SCAN: begin
            if (scan_done) begin
               pack_ctrl.append = 1'b1;
               state_in         = pce_pkg::ST_CHECK;
            end else begin
               scan_ctrl.step = 1'b1;
               j_in           = j_ff + IDX_W'(1);
            end
         end
         pce_pkg::ST_CHECK: begin
            priority if (emit_now) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pack_byte;
               rsp_last_in  = at_last_index && (pack_bits <= BITS_W'(8));
               state_in     = pce_pkg::ST_EMIT;
            end else if (at_last_index) begin
               state_in = pce_pkg::ST_LOAD;
            end else begin
               i_in            = i_ff - IDX_W'(1);
               j_in            = '0;
               scan_ctrl.clear = 1'b1;
               state_in        = pce_pkg::ST_SCAN;
            end
         end
         pce_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               rsp_valid_in    = 1'b0;
               pack_ctrl.shift = 1'b1;
               state_in        = pce_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = pce_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pce_pkg::ST_LOAD;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (store_write) begin
         element_store_ff[count_ff] <= req_tdata[pce_pkg::ELEM_W-1:0];
      end
   end

endmodule

// ===== rtl/core/pce_checker.sv =====
// ----------------------------------------------------------------------------
// pce_checker: port-level checks of the permutation code encoder
// Watches the top-level ports and is bound to every encoder instance.
// ----------------------------------------------------------------------------
module pce_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       csr_pready
);

   // Loading and emitting never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result item is pending");

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("result item changed while stalled");

   // After the final byte is taken, the result valid drops and the block then returns to loading.
   a_last_then_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid ##1 req_tready))
      else $error("block not ready to load after the final byte");

   // A byte that is not the last keeps the input side closed.
   a_more_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (!req_tready ##1 !req_tready))
      else $error("input opened before the encoding finished");

   // The configuration port never waits.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port not ready");

endmodule

bind permutation_code_encoder pce_checker u_pce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
